// ===== design/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared widths and pipeline payload types for the closest-approach block.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int COORD_W   = 32;
  localparam int DIST_W    = 32;
  localparam int DP_W      = COORD_W + 1;
  localparam int DV_W      = COORD_W + 2;
  localparam int SQ_W      = 70;
  localparam int REM_W     = SQ_W + 1;
  localparam int LAM_BITS  = 32;
  localparam int LAM_W     = LAM_BITS + 1;
  localparam int MP_W      = DV_W + LAM_W;
  localparam int STEP_W    = MP_W - LAM_BITS;
  localparam int DC_W      = STEP_W + 1;
  localparam int FSQ_W     = 2 * DC_W;
  localparam int ISQ_W     = 2 * DIST_W;
  localparam int ISQ_STEPS = DIST_W;

  // Payload that travels from the front end through the divider.
  typedef struct packed {
    logic                       valid;
    logic                       interp;
    logic                       eq;
    logic [SQ_W-1:0]            sq;
    logic [REM_W-1:0]           rem;
    logic [SQ_W-1:0]            den;
    logic [LAM_W-1:0]           lam;
    logic [2:0][DP_W-1:0]       dp;
    logic [2:0][DV_W-1:0]       dv;
  } work_t;

  typedef struct packed {
    logic             valid;
    logic [FSQ_W-1:0] sq;
  } sq_t;

endpackage

// ===== design/cpa_front.sv =====
// ----------------------------------------------------------------------------
// cpa_front
// Differences, products, dot sums and the early-exit decisions (4 stages).
// ----------------------------------------------------------------------------
module cpa_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [2:0][cpa_pkg::COORD_W-1:0]   bead_past,
  input  logic [2:0][cpa_pkg::COORD_W-1:0]   bead_now,
  input  logic [2:0][cpa_pkg::COORD_W-1:0]   point_past,
  input  logic [2:0][cpa_pkg::COORD_W-1:0]   point_now,
  input  logic [cpa_pkg::DIST_W-1:0]         min_distance,
  output cpa_pkg::work_t                     fe
);
  import cpa_pkg::*;

  logic signed [DP_W-1:0]        dp_c [3];
  logic signed [DP_W-1:0]        dn_c [3];

  logic                          v1;
  logic signed [DP_W-1:0]        dp1 [3];
  logic signed [DP_W-1:0]        dn1 [3];
  logic signed [DV_W-1:0]        dv1 [3];

  logic signed [2*DP_W-1:0]      m_dn [3];
  logic signed [2*DP_W-1:0]      m_dp [3];
  logic signed [2*DV_W-1:0]      m_dv [3];
  logic signed [DP_W+DV_W-1:0]   m_dot [3];
  logic [2*DIST_W-1:0]           m_min;

  logic                          v2;
  logic signed [SQ_W-1:0]        pdn [3];
  logic signed [SQ_W-1:0]        pdp [3];
  logic signed [SQ_W-1:0]        pdv [3];
  logic signed [SQ_W-1:0]        pdot [3];
  logic [2*DIST_W-1:0]           min2_2;
  logic [2:0][DP_W-1:0]          dp2;
  logic [2:0][DV_W-1:0]          dv2;

  logic                          v3;
  logic [SQ_W-1:0]               dnow2;
  logic [SQ_W-1:0]               dpp2;
  logic [SQ_W-1:0]               dvv;
  logic signed [SQ_W-1:0]        dot;
  logic [2*DIST_W-1:0]           min2_3;
  logic [2:0][DP_W-1:0]          dp3;
  logic [2:0][DV_W-1:0]          dv3;

  logic                          less;
  logic                          dvv_zero;
  logic                          dot_pos;
  logic [SQ_W-1:0]               n;
  work_t                         fe_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dp_c[i] = $signed({bead_past[i][COORD_W-1], bead_past[i]})
              - $signed({point_past[i][COORD_W-1], point_past[i]});
      dn_c[i] = $signed({bead_now[i][COORD_W-1], bead_now[i]})
              - $signed({point_now[i][COORD_W-1], point_now[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      for (int i = 0; i < 3; i++) begin
        dp1[i] <= dp_c[i];
        dn1[i] <= dn_c[i];
        dv1[i] <= $signed({dn_c[i][DP_W-1], dn_c[i]}) - $signed({dp_c[i][DP_W-1], dp_c[i]});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_dn[i]  = dn1[i] * dn1[i];
      m_dp[i]  = dp1[i] * dp1[i];
      m_dv[i]  = dv1[i] * dv1[i];
      m_dot[i] = dp1[i] * dv1[i];
    end
    m_min = min_distance * min_distance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2     <= v1;
      min2_2 <= m_min;
      for (int i = 0; i < 3; i++) begin
        pdn[i]  <= {{(SQ_W-2*DP_W){m_dn[i][2*DP_W-1]}}, m_dn[i]};
        pdp[i]  <= {{(SQ_W-2*DP_W){m_dp[i][2*DP_W-1]}}, m_dp[i]};
        pdv[i]  <= {{(SQ_W-2*DV_W){m_dv[i][2*DV_W-1]}}, m_dv[i]};
        pdot[i] <= {{(SQ_W-DP_W-DV_W){m_dot[i][DP_W+DV_W-1]}}, m_dot[i]};
        dp2[i]  <= dp1[i];
        dv2[i]  <= dv1[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3     <= v2;
      dnow2  <= pdn[0] + pdn[1] + pdn[2];
      dpp2   <= pdp[0] + pdp[1] + pdp[2];
      dvv    <= pdv[0] + pdv[1] + pdv[2];
      dot    <= pdot[0] + pdot[1] + pdot[2];
      min2_3 <= min2_2;
      dp3    <= dp2;
      dv3    <= dv2;
    end
  end

  // A positive dot product means lambda is below zero; the past distance wins.
  always_comb begin
    less     = dnow2 < {{(SQ_W-2*DIST_W){1'b0}}, min2_3};
    dvv_zero = dvv == '0;
    dot_pos  = !dot[SQ_W-1] && (dot != '0);
    n        = -dot;
    fe_next        = '0;
    fe_next.valid  = v3;
    fe_next.sq     = (!less && !dvv_zero && dot_pos) ? dpp2 : dnow2;
    fe_next.interp = !less && !dvv_zero && !dot_pos && !(n > dvv);
    fe_next.eq     = n == dvv;
    fe_next.rem    = {1'b0, n};
    fe_next.den    = dvv;
    fe_next.lam    = '0;
    fe_next.dp     = dp3;
    fe_next.dv     = dv3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fe.valid <= 1'b0;
    end else if (en) begin
      fe <= fe_next;
    end
  end

endmodule

// ===== design/cpa_div.sv =====
// ----------------------------------------------------------------------------
// cpa_div
// Restoring divider for lambda, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module cpa_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cpa_pkg::work_t din,
  output cpa_pkg::work_t dout
);
  import cpa_pkg::*;

  work_t pipe [LAM_BITS+1];

  assign pipe[0] = din;
  assign dout    = pipe[LAM_BITS];

  for (genvar k = 0; k < LAM_BITS; k++) begin : g_stage
    logic [REM_W-1:0] r2;
    logic             ge;
    work_t            nx;

    always_comb begin
      r2      = {pipe[k].rem[REM_W-2:0], 1'b0};
      ge      = r2 >= {1'b0, pipe[k].den};
      nx      = pipe[k];
      nx.rem  = ge ? (r2 - {1'b0, pipe[k].den}) : r2;
      nx.lam  = {pipe[k].lam[LAM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k+1].valid <= 1'b0;
      end else if (en) begin
        pipe[k+1] <= nx;
      end
    end
  end

endmodule

// ===== design/cpa_interp.sv =====
// ----------------------------------------------------------------------------
// cpa_interp
// Interpolated offset Dp + lambda*Dv and its squared length (4 stages).
// ----------------------------------------------------------------------------
module cpa_interp (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cpa_pkg::work_t din,
  output cpa_pkg::sq_t   dout
);
  import cpa_pkg::*;

  logic [LAM_W-1:0]        lam_eff;
  logic [DV_W-1:0]         mag [3];

  logic                    v1;
  logic                    interp1;
  logic [SQ_W-1:0]         sq1;
  logic [2:0]              neg1;
  logic [2:0][DP_W-1:0]    dp1;
  logic [MP_W-1:0]         p1 [3];

  logic [MP_W-1:0]         rnd [3];

  logic                    v2;
  logic                    interp2;
  logic [SQ_W-1:0]         sq2;
  logic signed [DC_W-1:0]  dc2 [3];

  logic signed [FSQ_W-1:0] m_dc [3];

  logic                    v3;
  logic                    interp3;
  logic [SQ_W-1:0]         sq3;
  logic [FSQ_W-1:0]        pdc [3];

  logic [FSQ_W-1:0]        sum;

  always_comb begin
    lam_eff = din.eq ? {1'b1, {LAM_BITS{1'b0}}} : din.lam;
    for (int i = 0; i < 3; i++) begin
      mag[i] = din.dv[i][DV_W-1] ? (-din.dv[i]) : din.dv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1      <= din.valid;
      interp1 <= din.interp;
      sq1     <= din.sq;
      dp1     <= din.dp;
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= din.dv[i][DV_W-1];
        p1[i]   <= mag[i] * lam_eff;
      end
    end
  end

  // Round each step to the coordinate grid, half away from zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = p1[i] + (MP_W'(1) << (LAM_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2      <= v1;
      interp2 <= interp1;
      sq2     <= sq1;
      for (int i = 0; i < 3; i++) begin
        if (neg1[i]) begin
          dc2[i] <= $signed({{(DC_W-DP_W){dp1[i][DP_W-1]}}, dp1[i]})
                  - $signed({1'b0, rnd[i][MP_W-1:LAM_BITS]});
        end else begin
          dc2[i] <= $signed({{(DC_W-DP_W){dp1[i][DP_W-1]}}, dp1[i]})
                  + $signed({1'b0, rnd[i][MP_W-1:LAM_BITS]});
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_dc[i] = dc2[i] * dc2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3      <= v2;
      interp3 <= interp2;
      sq3     <= sq2;
      for (int i = 0; i < 3; i++) begin
        pdc[i] <= m_dc[i];
      end
    end
  end

  assign sum = pdc[0] + pdc[1] + pdc[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= v3;
      dout.sq    <= interp3 ? sum : {{(FSQ_W-SQ_W){1'b0}}, sq3};
    end
  end

endmodule

// ===== design/cpa_isqrt.sv =====
// ----------------------------------------------------------------------------
// cpa_isqrt
// Pipelined integer square root, one result bit per stage, with saturation.
// ----------------------------------------------------------------------------
module cpa_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  cpa_pkg::sq_t              din,
  output logic                      dout_valid,
  output logic [cpa_pkg::DIST_W-1:0] dout
);
  import cpa_pkg::*;

  typedef struct packed {
    logic             valid;
    logic             sat;
    logic [ISQ_W-1:0] n;
    logic [ISQ_W-1:0] res;
  } isq_t;

  isq_t pipe [ISQ_STEPS+1];

  always_comb begin
    pipe[0].valid = din.valid;
    pipe[0].sat   = din.sq[FSQ_W-1:ISQ_W] != '0;
    pipe[0].n     = din.sq[ISQ_W-1:0];
    pipe[0].res   = '0;
  end

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_stage
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (ISQ_W - 2 - 2 * k);
    logic [ISQ_W-1:0] trial;
    logic             ge;
    isq_t             nx;

    always_comb begin
      trial  = pipe[k].res + BIT;
      ge     = pipe[k].n >= trial;
      nx     = pipe[k];
      nx.n   = ge ? (pipe[k].n - trial) : pipe[k].n;
      nx.res = ge ? ((pipe[k].res >> 1) + BIT) : (pipe[k].res >> 1);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k+1].valid <= 1'b0;
      end else if (en) begin
        pipe[k+1] <= nx;
      end
    end
  end

  assign dout_valid = pipe[ISQ_STEPS].valid;
  assign dout       = pipe[ISQ_STEPS].sat ? '1 : pipe[ISQ_STEPS].res[DIST_W-1:0];

endmodule

// ===== design/moving_points_closest_approach.sv =====
// ----------------------------------------------------------------------------
// moving_points_closest_approach
// Closest distance of two points moving linearly between past and now.
// ----------------------------------------------------------------------------
// Usage: an input transaction (in_valid/in_ready) carries the past and current
// Q16.16 positions of a bead and of one chain point. One output transaction
// (out_valid/out_ready) per input returns the minimum distance, unsigned
// Q16.16, saturated to all ones.
// The pipeline has 4 front stages (differences, products, sums, decisions),
// 32 divider stages (one lambda bit each), 4 interpolation stages and 32
// square-root stages (one result bit each). Throughput is one item per cycle
// unless the receiver stalls; the depth is set by the bit-per-stage divider
// and square root. min_distance must be written through cfg_wr_en/cfg_wr_data
// only while idle; the block itself does not enforce this. Reset (synchronous)
// clears all stage valid bits and min_distance. When the receiver stalls, the
// whole pipeline holds and in_ready drops; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module moving_points_closest_approach (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [cpa_pkg::DIST_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cpa_pkg::COORD_W-1:0] bead_past_x,
  input  logic [cpa_pkg::COORD_W-1:0] bead_past_y,
  input  logic [cpa_pkg::COORD_W-1:0] bead_past_z,
  input  logic [cpa_pkg::COORD_W-1:0] bead_now_x,
  input  logic [cpa_pkg::COORD_W-1:0] bead_now_y,
  input  logic [cpa_pkg::COORD_W-1:0] bead_now_z,
  input  logic [cpa_pkg::COORD_W-1:0] point_past_x,
  input  logic [cpa_pkg::COORD_W-1:0] point_past_y,
  input  logic [cpa_pkg::COORD_W-1:0] point_past_z,
  input  logic [cpa_pkg::COORD_W-1:0] point_now_x,
  input  logic [cpa_pkg::COORD_W-1:0] point_now_y,
  input  logic [cpa_pkg::COORD_W-1:0] point_now_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cpa_pkg::DIST_W-1:0]  closest_distance
);
  import cpa_pkg::*;

  logic                     en;
  logic [DIST_W-1:0]        min_distance;
  logic [2:0][COORD_W-1:0]  bead_past;
  logic [2:0][COORD_W-1:0]  bead_now;
  logic [2:0][COORD_W-1:0]  point_past;
  logic [2:0][COORD_W-1:0]  point_now;
  work_t                    fe;
  work_t                    dq;
  sq_t                      sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= '0;
    end else if (cfg_wr_en) begin
      min_distance <= cfg_wr_data;
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign bead_past  = {bead_past_z, bead_past_y, bead_past_x};
  assign bead_now   = {bead_now_z, bead_now_y, bead_now_x};
  assign point_past = {point_past_z, point_past_y, point_past_x};
  assign point_now  = {point_now_z, point_now_y, point_now_x};

  cpa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_valid),
    .bead_past    (bead_past),
    .bead_now     (bead_now),
    .point_past   (point_past),
    .point_now    (point_now),
    .min_distance (min_distance),
    .fe           (fe)
  );

  cpa_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (fe),
    .dout (dq)
  );

  cpa_interp u_interp (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (dq),
    .dout (sq)
  );

  cpa_isqrt u_isqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .din        (sq),
    .dout_valid (out_valid),
    .dout       (closest_distance)
  );

`ifndef SYNTHESIS
  a_interp_den: assert property (@(posedge clk) disable iff (rst)
    fe.valid && fe.interp |-> fe.den != '0)
    else $error("interpolation selected with zero relative motion");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dq.valid && dq.interp && !dq.eq |-> dq.rem < {1'b0, dq.den})
    else $error("divider remainder not below divisor");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(fe) && $stable(dq))
    else $error("pipeline moved during a stall");
`endif

endmodule
